### sv/redundant_safety_frame_checker_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the safety frame checker
// Shared clocking and reporting for the port-level assertions.
// ---------------------------------------------------------------------------
`ifndef REDUNDANT_SAFETY_FRAME_CHECKER_MACROS_SVH
`define REDUNDANT_SAFETY_FRAME_CHECKER_MACROS_SVH

// check outside reset
`define RSFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check at every edge, reset included
`define RSFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rsfc_pkg.sv
// ---------------------------------------------------------------------------
// Safety frame checker package
// Frame constants, item and result types, and the Modbus CRC-16 byte step.
// ---------------------------------------------------------------------------
package rsfc_pkg;

	localparam int FRAME_BYTES = 12;
	localparam int CNT_W       = 4;
	localparam int COPY_BYTES  = 4;

	localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] COPY_END  = CNT_W'(COPY_BYTES);
	localparam logic [CNT_W-1:0] CMP_END   = CNT_W'(2 * COPY_BYTES);
	localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
	localparam logic [15:0]      CRC_POLY  = 16'hA001;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic [1:0] expected_connection;
		logic [7:0] expected_seqn;
		logic       partner_valid;
	} item_t;

	typedef struct packed {
		logic       frame_valid;
		logic       both_valid;
		logic [7:0] sensor_low;
		logic [7:0] sensor_high;
		logic [5:0] fault_bits;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

### sv/rsfc_in_stage.sv
// ---------------------------------------------------------------------------
// Input stage
// Registers one accepted item; stalls only when the held item cannot advance.
// ---------------------------------------------------------------------------
module rsfc_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  rsfc_pkg::item_t in_item,
	input  logic            advance,
	output logic            in_stall,
	output logic            valid_s1,
	output rsfc_pkg::item_t item_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### sv/rsfc_frame_core.sv
// ---------------------------------------------------------------------------
// Frame core
// Byte position, CRC register, copy store and compare, end-of-frame check.
// ---------------------------------------------------------------------------
module rsfc_frame_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  rsfc_pkg::item_t   item_s1,
	input  logic              advance,
	output logic              res_valid,
	output rsfc_pkg::result_t res
);

	logic [rsfc_pkg::CNT_W-1:0] cnt_q;
	logic                       active_q;
	logic [15:0]                crc_q;
	logic                       mism_q;
	logic [7:0]                 copy_q [rsfc_pkg::COPY_BYTES];

	logic                       active_eff;
	logic [rsfc_pkg::CNT_W-1:0] idx;
	logic [15:0]                crc_next;
	logic                       mism_next;
	logic                       is_copy;
	logic                       is_cmp;
	logic                       is_last;
	logic                       good;
	logic                       step;

	always_comb begin
		active_eff = item_s1.first_byte || active_q;
		idx        = item_s1.first_byte ? '0 : cnt_q;
		crc_next   = rsfc_pkg::crc_byte(item_s1.first_byte ? rsfc_pkg::CRC_INIT : crc_q,
			item_s1.data_byte);
		is_copy    = idx < rsfc_pkg::COPY_END;
		is_cmp     = !is_copy && (idx < rsfc_pkg::CMP_END);
		mism_next  = (!item_s1.first_byte && mism_q) ||
			(is_cmp && (item_s1.data_byte != copy_q[idx[1:0]]));
		is_last    = idx == rsfc_pkg::LAST_IDX;
		step       = valid_s1 && advance && active_eff;
		good       = (crc_next == 16'h0000) && !mism_next &&
			(copy_q[0][1:0] == item_s1.expected_connection) &&
			(copy_q[3] == item_s1.expected_seqn);
	end

	assign res_valid = valid_s1 && active_eff && is_last;

	always_comb begin
		res.frame_valid = good;
		res.both_valid  = good && item_s1.partner_valid;
		res.sensor_low  = good ? copy_q[1] : 8'h00;
		res.sensor_high = good ? copy_q[2] : 8'h00;
		res.fault_bits  = good ? copy_q[0][7:2] : 6'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			active_q <= 1'b0;
			crc_q    <= rsfc_pkg::CRC_INIT;
			mism_q   <= 1'b0;
		end else if (step) begin
			crc_q  <= crc_next;
			mism_q <= mism_next;
			if (is_last) begin
				active_q <= 1'b0;
				cnt_q    <= '0;
			end else begin
				active_q <= 1'b1;
				cnt_q    <= idx + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_copy) begin
			copy_q[idx[1:0]] <= item_s1.data_byte;
		end
	end

endmodule

### sv/rsfc_out_stage.sv
// ---------------------------------------------------------------------------
// Output stage
// Holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
module rsfc_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  rsfc_pkg::result_t res,
	input  logic              out_stall,
	output logic              slot_free,
	output logic              out_valid,
	output rsfc_pkg::result_t out_res
);

	assign slot_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_res <= res;
		end
	end

endmodule

### sv/redundant_safety_frame_checker.sv
// ---------------------------------------------------------------------------
// Redundant safety frame checker
// Checks a byte-serial safety frame: CRC-16, copy bytes, connection, sequence.
// ---------------------------------------------------------------------------
// One byte is taken per cycle, back to back, while in_stall is low; the CRC byte
// step, copy compare and end-of-frame check are combinational between the input
// register and the result register, so the result for the last byte of a frame is
// registered as that byte leaves the input register. A byte flagged first_byte
// starts a frame; bytes outside a frame are dropped without a result. When
// frame_valid is low the sensor and fault fields read as zero.
module redundant_safety_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic [1:0] expected_connection,
	input  logic [7:0] expected_seqn,
	input  logic       partner_valid,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       frame_valid,
	output logic       both_valid,
	output logic [7:0] sensor_low,
	output logic [7:0] sensor_high,
	output logic [5:0] fault_bits
);

	rsfc_pkg::item_t   in_item;
	rsfc_pkg::item_t   item_s1;
	rsfc_pkg::result_t res;
	rsfc_pkg::result_t out_res;
	logic              valid_s1;
	logic              slot_free;
	logic              res_valid;

	always_comb begin
		in_item.data_byte           = data_byte;
		in_item.first_byte          = first_byte;
		in_item.expected_connection = expected_connection;
		in_item.expected_seqn       = expected_seqn;
		in_item.partner_valid       = partner_valid;
	end

	rsfc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.advance  (slot_free),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rsfc_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (slot_free),
		.res_valid (res_valid),
		.res       (res)
	);

	rsfc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign frame_valid = out_res.frame_valid;
	assign both_valid  = out_res.both_valid;
	assign sensor_low  = out_res.sensor_low;
	assign sensor_high = out_res.sensor_high;
	assign fault_bits  = out_res.fault_bits;

endmodule

### sv/rsfc_checker.sv
// ---------------------------------------------------------------------------
// Safety frame checker port assertions
// Port-level checks on result items and on reset, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "redundant_safety_frame_checker_macros.svh"

module rsfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       frame_valid,
	input logic       both_valid,
	input logic [7:0] sensor_low,
	input logic [7:0] sensor_high,
	input logic [5:0] fault_bits
);

	`RSFC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(frame_valid) && $stable(both_valid) && $stable(sensor_low) && $stable(sensor_high) && $stable(fault_bits), "result item changed while stalled")
	`RSFC_ASSERT(a_both_implies_frame, out_valid && both_valid |-> frame_valid, "both_valid without frame_valid")
	`RSFC_ASSERT(a_invalid_zero, out_valid && !frame_valid |-> sensor_low == 8'h00 && sensor_high == 8'h00 && fault_bits == 6'h00, "fields not zero on invalid frame")
	`RSFC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid && !in_stall, "output active during reset")

endmodule

bind redundant_safety_frame_checker rsfc_checker u_rsfc_checker (.*);

### tb/tb_redundant_safety_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Safety frame checker testbench
// Streams byte-serial safety frames, clean and damaged, with idle and restart
// bytes, under random sender gaps and receiver stalls. A local frame tracker
// predicts every verdict, which is matched field by field against the output.
// ---------------------------------------------------------------------------
module tb_redundant_safety_frame_checker;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 330;
	localparam int DRAIN_CYCLES    = 20;

	typedef enum int {
		FRAME_CLEAN,
		FRAME_BAD_CRC,
		FRAME_BAD_COPY,
		FRAME_BAD_FAULT,
		FRAME_BAD_CONN,
		FRAME_BAD_SEQN,
		FRAME_CUT
	} frame_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b1;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = '0;
	logic       first_byte = 1'b0;
	logic [1:0] expected_connection = '0;
	logic [7:0] expected_seqn = '0;
	logic       partner_valid = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       frame_valid;
	logic       both_valid;
	logic [7:0] sensor_low;
	logic [7:0] sensor_high;
	logic [5:0] fault_bits;

	rsfc_pkg::item_t   pending_q[$];
	rsfc_pkg::result_t verdict_q[$];
	rsfc_pkg::item_t   next_item;
	rsfc_pkg::item_t   seen_item;
	rsfc_pkg::result_t want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int cycle_count = 0;
	int pushed = 0;

	// frame tracker state
	logic [3:0]  trk_pos = '0;
	logic        trk_active = 1'b0;
	logic [15:0] trk_crc = rsfc_pkg::CRC_INIT;
	logic [7:0]  trk_kept [rsfc_pkg::COPY_BYTES] = '{default: 8'h00};
	logic        trk_copy_bad = 1'b0;

	redundant_safety_frame_checker uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.data_byte           (data_byte),
		.first_byte          (first_byte),
		.expected_connection (expected_connection),
		.expected_seqn       (expected_seqn),
		.partner_valid       (partner_valid),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.frame_valid         (frame_valid),
		.both_valid          (both_valid),
		.sensor_low          (sensor_low),
		.sensor_high         (sensor_high),
		.fault_bits          (fault_bits)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] v;
		v = acc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ rsfc_pkg::CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

	task automatic track_frame_byte(input rsfc_pkg::item_t it);
		logic              ok;
		rsfc_pkg::result_t r;
		if (it.first_byte) begin
			trk_pos = '0;
			trk_active = 1'b1;
			trk_crc = rsfc_pkg::CRC_INIT;
			trk_copy_bad = 1'b0;
		end
		if (trk_active) begin
			trk_crc = modbus_crc_next(trk_crc, it.data_byte);
			if (trk_pos < rsfc_pkg::COPY_END) begin
				trk_kept[trk_pos[1:0]] = it.data_byte;
			end else if (trk_pos < rsfc_pkg::CMP_END) begin
				if (it.data_byte != trk_kept[trk_pos[1:0]]) begin
					trk_copy_bad = 1'b1;
				end
			end
			if (trk_pos == rsfc_pkg::LAST_IDX) begin
				trk_active = 1'b0;
				trk_pos = '0;
				ok = (trk_crc == 16'h0000) && !trk_copy_bad &&
					(trk_kept[0][1:0] == it.expected_connection) &&
					(trk_kept[3] == it.expected_seqn);
				r.frame_valid = ok;
				r.both_valid  = ok && it.partner_valid;
				r.sensor_low  = ok ? trk_kept[1] : 8'h00;
				r.sensor_high = ok ? trk_kept[2] : 8'h00;
				r.fault_bits  = ok ? trk_kept[0][7:2] : 6'h00;
				verdict_q.push_back(r);
			end else begin
				trk_pos = trk_pos + 4'd1;
			end
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			error_count++;
		end
	endtask

	task automatic add_item(input logic [7:0] b, input logic first, input logic [1:0] conn,
		input logic [7:0] seqn, input logic partner);
		rsfc_pkg::item_t it;
		it.data_byte = b;
		it.first_byte = first;
		it.expected_connection = conn;
		it.expected_seqn = seqn;
		it.partner_valid = partner;
		pending_q.push_back(it);
		pushed++;
	endtask

	task automatic push_frame(input frame_kind_t kind, input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic partner);
		logic [7:0]  fb [rsfc_pkg::FRAME_BYTES];
		logic [15:0] acc;
		logic [1:0]  conn;
		logic [7:0]  seqn;
		int          idx;
		int          cut;
		fb[0] = b0;
		fb[1] = b1;
		fb[2] = b2;
		fb[3] = b3;
		for (int i = rsfc_pkg::COPY_BYTES; i < rsfc_pkg::FRAME_BYTES; i++) begin
			fb[i] = (i < 2 * rsfc_pkg::COPY_BYTES) ? fb[i - rsfc_pkg::COPY_BYTES] : 8'($urandom);
		end
		if (kind == FRAME_BAD_COPY) begin
			idx = $urandom_range(rsfc_pkg::COPY_BYTES, 2 * rsfc_pkg::COPY_BYTES - 1);
			fb[idx] ^= 8'($urandom_range(1, 255));
		end else if (kind == FRAME_BAD_FAULT) begin
			fb[rsfc_pkg::COPY_BYTES] ^= {6'($urandom_range(1, 63)), 2'b00};
		end
		acc = rsfc_pkg::CRC_INIT;
		for (int i = 0; i < rsfc_pkg::FRAME_BYTES - 2; i++) begin
			acc = modbus_crc_next(acc, fb[i]);
		end
		fb[rsfc_pkg::FRAME_BYTES - 2] = acc[7:0];
		fb[rsfc_pkg::FRAME_BYTES - 1] = acc[15:8];
		if (kind == FRAME_BAD_CRC) begin
			idx = $urandom_range(2 * rsfc_pkg::COPY_BYTES, rsfc_pkg::FRAME_BYTES - 1);
			fb[idx] ^= 8'(1 << $urandom_range(7));
		end
		conn = fb[0][1:0];
		seqn = fb[3];
		if (kind == FRAME_BAD_CONN) begin
			conn ^= 2'($urandom_range(1, 3));
		end
		if (kind == FRAME_BAD_SEQN) begin
			seqn ^= 8'($urandom_range(1, 255));
		end
		cut = (kind == FRAME_CUT) ? $urandom_range(1, rsfc_pkg::FRAME_BYTES - 1) :
			rsfc_pkg::FRAME_BYTES;
		for (int i = 0; i < cut; i++) begin
			if (i == rsfc_pkg::FRAME_BYTES - 1) begin
				add_item(fb[i], 1'b0, conn, seqn, partner);
			end else begin
				add_item(fb[i], i == 0, 2'($urandom), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			first_byte <= 1'b0;
			expected_connection <= '0;
			expected_seqn <= '0;
			partner_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_item.data_byte;
				first_byte <= next_item.first_byte;
				expected_connection <= next_item.expected_connection;
				expected_seqn <= next_item.expected_seqn;
				partner_valid <= next_item.partner_valid;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("result with no verdict pending");
					error_count++;
				end else begin
					want = verdict_q.pop_front();
					check_field("frame_valid", want.frame_valid, frame_valid);
					check_field("both_valid", want.both_valid, both_valid);
					check_field("sensor_low", want.sensor_low, sensor_low);
					check_field("sensor_high", want.sensor_high, sensor_high);
					check_field("fault_bits", want.fault_bits, fault_bits);
				end
			end
			if (in_valid && !in_stall) begin
				seen_item.data_byte = data_byte;
				seen_item.first_byte = first_byte;
				seen_item.expected_connection = expected_connection;
				seen_item.expected_seqn = expected_seqn;
				seen_item.partner_valid = partner_valid;
				track_frame_byte(seen_item);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("redundant_safety_frame_checker test failed");
			$finish;
		end
	end

	initial begin
		int          sel;
		int          target;
		frame_kind_t kind;
		target = 0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 56 : 0;
			recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 16 : 0;
			target += ITEMS_PER_PHASE;
			if (phase == 0) begin
				// stray byte, then a restart, then extremes and a fault-bit copy error
				add_item(8'h5A, 1'b0, 2'd0, 8'h00, 1'b0);
				add_item(8'hA5, 1'b1, 2'd1, 8'h11, 1'b1);
				push_frame(FRAME_CLEAN, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1);
				add_item(8'hFF, 1'b0, 2'd3, 8'hFF, 1'b1);
				push_frame(FRAME_BAD_FAULT, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1);
			end
			while (pushed < target) begin
				sel = $urandom_range(99);
				if (sel < 10) begin
					repeat ($urandom_range(1, 6)) begin
						add_item(8'($urandom), $urandom_range(99) < 15, 2'($urandom),
							8'($urandom), 1'($urandom));
					end
				end else begin
					sel = $urandom_range(99);
					if (sel < 50) kind = FRAME_CLEAN;
					else if (sel < 58) kind = FRAME_BAD_CRC;
					else if (sel < 66) kind = FRAME_BAD_COPY;
					else if (sel < 72) kind = FRAME_BAD_FAULT;
					else if (sel < 80) kind = FRAME_BAD_CONN;
					else if (sel < 88) kind = FRAME_BAD_SEQN;
					else kind = FRAME_CUT;
					push_frame(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom));
				end
			end
			while (pending_q.size() != 0) @(posedge clk);
		end
		while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$error("%0d verdicts never arrived", verdict_q.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("redundant_safety_frame_checker test passed");
		end else begin
			$display("redundant_safety_frame_checker test failed");
		end
		$finish;
	end

endmodule
